/* rtl/xor_kbucket_routing_table_defines.svh */
// Assertion helpers shared by the routing table modules.
`ifndef XOR_KBUCKET_ROUTING_TABLE_DEFINES_SVH
`define XOR_KBUCKET_ROUTING_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTBL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("routing table check failed");

// Next-cycle implication, checked outside reset.
`define RTBL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("routing table check failed");

`endif

/* rtl/rtbl_pkg.sv */
package rtbl_pkg;

    // Table geometry.
    localparam int KEY_BITS    = 64;
    localparam int BUCKET_WAYS = 8;
    localparam int MAX_CLOSEST = 16;
    localparam int DATA_BITS   = 48;

    localparam int SLOTS   = KEY_BITS * BUCKET_WAYS;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int BKT_W   = $clog2(KEY_BITS);
    localparam int CAP     = (MAX_CLOSEST < 16) ? MAX_CLOSEST : 16;
    localparam int CAP_AW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int FILL_W  = $clog2(CAP + 1);
    localparam int D_W     = (DATA_BITS < 48) ? DATA_BITS : 48;

    // Operation codes.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_TOUCH  = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_UPDATED = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key;
        logic [47:0] peer_data;
        logic [63:0] seen_time;
        logic [63:0] now;
        logic [4:0]  want;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] out_key;
        logic [47:0] out_data;
        logic [63:0] out_seen;
        logic [4:0]  found_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic                act;
        logic [KEY_BITS-1:0] key;
        logic [D_W-1:0]      data;
        logic [63:0]         seen;
    } t_slot;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;
        logic scan_init;
        logic res_fail;
        logic cnt_clr;
        logic cnt_inc;
        logic clr_wr;
        logic rd_bkt;
        logic rd_all;
        logic commit;
        logic out_res;
        logic out_emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_find;
        logic op_bad;
        logic key_self;
        logic end_ways;
        logic end_slots;
        logic emit_last;
    } t_stat;

endpackage

/* rtl/rtbl_ctrl.sv */
`include "xor_kbucket_routing_table_defines.svh"

module rtbl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  rtbl_pkg::t_stat i_stat,
    output rtbl_pkg::t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_CLZ    = 10'b0000000100,
        S_SCAN   = 10'b0000001000,
        S_DRAIN  = 10'b0000010000,
        S_COMMIT = 10'b0000100000,
        S_RESP   = 10'b0001000000,
        S_FIND   = 10'b0010000000,
        S_FDRAIN = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;
    rtbl_pkg::t_cmd cmd;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

    // Next state and commands.
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (i_stat.end_slots) begin
                    cmd.cnt_clr = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    n_state = S_CLZ;
                end
            end
            S_CLZ: begin
                cmd.scan_init = 1'b1;
                cmd.cnt_clr   = 1'b1;
                if (i_stat.op_find) begin
                    n_state = S_FIND;
                end else if (i_stat.op_bad || i_stat.key_self) begin
                    cmd.res_fail = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_bkt  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (i_stat.end_ways) begin
                    cmd.cnt_clr = 1'b1;
                    n_state     = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_COMMIT;
            S_COMMIT: begin
                cmd.commit = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    cmd.out_res = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_FIND: begin
                cmd.rd_all  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (i_stat.end_slots) begin
                    cmd.cnt_clr = 1'b1;
                    n_state     = S_FDRAIN;
                end
            end
            S_FDRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    cmd.out_emit = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    if (i_stat.emit_last) begin
                        cmd.cnt_clr = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Output register occupancy.
    always_comb begin
        n_out_vld = r_out_vld;
        if (cmd.out_res || cmd.out_emit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // A result beat is loaded only into a free output register.
    `RTBL_ASSERT_SAME(a_load_free, cmd.out_res || cmd.out_emit, !r_out_vld || i_out_ready)
    // An accepted beat always goes to decode.
    `RTBL_ASSERT_NEXT(a_accept_decode, i_in_valid && o_in_ready, r_state == S_CLZ)
    // The state register always holds exactly one state.
    `RTBL_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(r_state))

endmodule

/* rtl/rtbl_dp.sv */
`include "xor_kbucket_routing_table_defines.svh"

module rtbl_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [63:0]     i_cfg_data,
    input  rtbl_pkg::t_in   i_in,
    input  rtbl_pkg::t_cmd  i_cmd,
    output rtbl_pkg::t_stat o_stat,
    output rtbl_pkg::t_out  o_out
);

    localparam int KB  = rtbl_pkg::KEY_BITS;
    localparam int AW  = rtbl_pkg::SLOT_AW;
    localparam int FW  = rtbl_pkg::FILL_W;
    localparam int DW  = rtbl_pkg::D_W;
    localparam int CP  = rtbl_pkg::CAP;

    // Table storage.
    rtbl_pkg::t_slot mem [rtbl_pkg::SLOTS];

    logic [KB-1:0]              r_own;
    logic [2:0]                 r_op;
    logic [KB-1:0]              r_key;
    logic [DW-1:0]              r_data;
    logic [63:0]                r_seen;
    logic [63:0]                r_now;
    logic [FW-1:0]              r_want;
    logic [rtbl_pkg::BKT_W-1:0] r_bkt;
    logic [AW-1:0]              r_cnt;

    rtbl_pkg::t_slot r_rd;
    logic            r_rd_vld;
    logic            r_rd_find;
    logic [AW-1:0]   r_rd_addr;

    logic          r_hit, r_free, r_min_vld;
    logic [AW-1:0] r_hit_addr, r_free_addr, r_min_addr;
    logic [DW-1:0] r_hit_data;
    logic [63:0]   r_hit_seen, r_min_seen;

    logic [KB-1:0] r_best_key  [CP];
    logic [DW-1:0] r_best_data [CP];
    logic [63:0]   r_best_seen [CP];
    logic [FW-1:0] r_fill;

    rtbl_pkg::t_out r_res, r_out;

    // Leading-zero count of a nonzero distance.
    function automatic logic [rtbl_pkg::BKT_W-1:0] lzc(input logic [KB-1:0] d);
        logic [rtbl_pkg::BKT_W-1:0] n;
        n = '0;
        for (int b = 0; b < KB; b++) begin
            if (d[b]) begin
                n = rtbl_pkg::BKT_W'(KB - 1 - b);
            end
        end
        return n;
    endfunction

    function automatic rtbl_pkg::t_out fail_res();
        rtbl_pkg::t_out r;
        r        = '0;
        r.status = rtbl_pkg::ST_FAIL;
        r.last   = 1'b1;
        return r;
    endfunction

    // Status toward the controller.
    assign o_stat.op_find   = (r_op == rtbl_pkg::OP_FIND);
    assign o_stat.op_bad    = (r_op > rtbl_pkg::OP_FIND);
    assign o_stat.key_self  = ((r_key ^ r_own) == '0);
    assign o_stat.end_ways  = (r_cnt == AW'(rtbl_pkg::BUCKET_WAYS - 1));
    assign o_stat.end_slots = (r_cnt == AW'(rtbl_pkg::SLOTS - 1));
    assign o_stat.emit_last = (r_fill == '0) || (int'(r_cnt) + 1 == int'(r_fill));
    assign o_out            = r_out;

    // Read address for bucket scan or full walk.
    logic [AW-1:0] base, rd_addr;
    assign base    = AW'(r_bkt) * AW'(rtbl_pkg::BUCKET_WAYS);
    assign rd_addr = i_cmd.rd_bkt ? (base + r_cnt) : r_cnt;

    // Insertion into the sorted closest list.
    logic [KB-1:0] dist_e;
    logic [CP-1:0] tk;
    logic          take_any;
    logic [KB-1:0] n_best_key  [CP];
    logic [DW-1:0] n_best_data [CP];
    logic [63:0]   n_best_seen [CP];

    always_comb begin
        dist_e   = r_rd.key ^ r_key;
        take_any = 1'b0;
        for (int i = 0; i < CP; i++) begin
            if (FW'(i) < r_fill) begin
                tk[i] = dist_e < (r_best_key[i] ^ r_key);
            end else begin
                tk[i] = (FW'(i) == r_fill);
            end
            if (tk[i] && FW'(i) < r_want) begin
                take_any = 1'b1;
            end
        end
        n_best_key[0]  = tk[0] ? r_rd.key  : r_best_key[0];
        n_best_data[0] = tk[0] ? r_rd.data : r_best_data[0];
        n_best_seen[0] = tk[0] ? r_rd.seen : r_best_seen[0];
        for (int i = 1; i < CP; i++) begin
            if (tk[i] && tk[i-1]) begin
                n_best_key[i]  = r_best_key[i-1];
                n_best_data[i] = r_best_data[i-1];
                n_best_seen[i] = r_best_seen[i-1];
            end else if (tk[i]) begin
                n_best_key[i]  = r_rd.key;
                n_best_data[i] = r_rd.data;
                n_best_seen[i] = r_rd.seen;
            end else begin
                n_best_key[i]  = r_best_key[i];
                n_best_data[i] = r_best_data[i];
                n_best_seen[i] = r_best_seen[i];
            end
        end
    end

    // Commit of a bucket operation: memory write and pending result.
    logic            we;
    logic [AW-1:0]   waddr;
    rtbl_pkg::t_slot wdata;
    rtbl_pkg::t_out  commit_res;
    logic [63:0]     seen_eff;

    always_comb begin
        seen_eff   = (r_seen == '0) ? r_now : r_seen;
        we         = 1'b0;
        waddr      = r_cnt;
        wdata      = '0;
        commit_res = fail_res();
        if (i_cmd.clr_wr) begin
            we = 1'b1;
        end else if (i_cmd.commit) begin
            unique case (r_op)
                rtbl_pkg::OP_INSERT: begin
                    we         = 1'b1;
                    waddr      = r_hit ? r_hit_addr : (r_free ? r_free_addr : r_min_addr);
                    wdata      = {1'b1, r_key, r_data, seen_eff};
                    commit_res = {r_hit ? rtbl_pkg::ST_UPDATED : rtbl_pkg::ST_DONE,
                                  64'(r_key), 48'(r_data), seen_eff, 5'd0, 1'b1};
                end
                rtbl_pkg::OP_REMOVE: begin
                    if (r_hit) begin
                        we         = 1'b1;
                        waddr      = r_hit_addr;
                        commit_res = {rtbl_pkg::ST_DONE, 64'(r_key), 48'd0, 64'd0,
                                      5'd0, 1'b1};
                    end
                end
                rtbl_pkg::OP_LOOKUP: begin
                    if (r_hit) begin
                        commit_res = {rtbl_pkg::ST_DONE, 64'(r_key), 48'(r_hit_data),
                                      r_hit_seen, 5'd0, 1'b1};
                    end
                end
                rtbl_pkg::OP_TOUCH: begin
                    if (r_hit) begin
                        we         = 1'b1;
                        waddr      = r_hit_addr;
                        wdata      = {1'b1, r_key, r_hit_data, r_now};
                        commit_res = {rtbl_pkg::ST_DONE, 64'(r_key), 48'(r_hit_data),
                                      r_now, 5'd0, 1'b1};
                    end
                end
                default: commit_res = fail_res();
            endcase
        end
    end

    // Result beat of the closest list.
    localparam int CAP_IW = rtbl_pkg::CAP_AW;
    rtbl_pkg::t_out     emit_res;
    logic [CAP_IW-1:0]  eidx;
    assign eidx = r_cnt[CAP_IW-1:0];
    always_comb begin
        if (r_fill == '0) begin
            emit_res = fail_res();
        end else begin
            emit_res = {rtbl_pkg::ST_DONE, 64'(r_best_key[eidx]), 48'(r_best_data[eidx]),
                        r_best_seen[eidx], 5'(r_fill), o_stat.emit_last};
        end
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_bkt || i_cmd.rd_all) begin
            r_rd <= mem[rd_addr];
        end
        r_rd_addr <= rd_addr;
        r_rd_find <= i_cmd.rd_all;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own    <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_fill   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_own <= i_cfg_data[KB-1:0];
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_rd_vld <= i_cmd.rd_bkt || i_cmd.rd_all;
            if (i_cmd.scan_init) begin
                r_fill <= '0;
            end else if (r_rd_vld && r_rd_find && r_rd.act && take_any && r_fill < r_want) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op   <= i_in.op;
            r_key  <= i_in.key[KB-1:0];
            r_data <= i_in.peer_data[DW-1:0];
            r_seen <= i_in.seen_time;
            r_now  <= i_in.now;
            r_want <= (i_in.want > 5'(CP)) ? FW'(CP) : FW'(i_in.want);
        end
        if (i_cmd.scan_init) begin
            r_bkt     <= lzc(r_key ^ r_own);
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_min_vld <= 1'b0;
        end else if (r_rd_vld && !r_rd_find) begin
            if (r_rd.act) begin
                if (!r_hit && r_rd.key == r_key) begin
                    r_hit      <= 1'b1;
                    r_hit_addr <= r_rd_addr;
                    r_hit_data <= r_rd.data;
                    r_hit_seen <= r_rd.seen;
                end
                if (!r_min_vld || r_rd.seen < r_min_seen) begin
                    r_min_vld  <= 1'b1;
                    r_min_addr <= r_rd_addr;
                    r_min_seen <= r_rd.seen;
                end
            end else if (!r_free) begin
                r_free      <= 1'b1;
                r_free_addr <= r_rd_addr;
            end
        end
        if (r_rd_vld && r_rd_find && r_rd.act && take_any) begin
            for (int i = 0; i < CP; i++) begin
                r_best_key[i]  <= n_best_key[i];
                r_best_data[i] <= n_best_data[i];
                r_best_seen[i] <= n_best_seen[i];
            end
        end
        if (i_cmd.res_fail) begin
            r_res <= fail_res();
        end else if (i_cmd.commit) begin
            r_res <= commit_res;
        end
        if (i_cmd.out_res) begin
            r_out <= r_res;
        end else if (i_cmd.out_emit) begin
            r_out <= emit_res;
        end
    end

    // The closest list never grows past the requested count.
    `RTBL_ASSERT_SAME(a_fill_want, r_rd_vld && r_rd_find, r_fill <= r_want)
    // A hit recorded by the scan lies at or above the base of the scanned bucket.
    `RTBL_ASSERT_SAME(a_hit_key, i_cmd.commit && r_hit, r_hit_addr >= base)
    // Emission stays inside the filled part of the list.
    `RTBL_ASSERT_SAME(a_emit_range, i_cmd.out_emit && r_fill != '0, int'(r_cnt) < int'(r_fill))

endmodule

/* rtl/xor_kbucket_routing_table.sv */
// A bucket operation steps through decode, a read of each of the 8 ways, drain, commit and
// output load; the next item is taken only once its result is loaded into the output register.
// Own key or unknown op: decode, then the fail result is loaded, with no table reads.
// Find closest reads all 512 slots, then gives one result beat per cycle while the output
// is not stalled. Reset is synchronous and active low; a clearing pass then marks every
// slot empty, and no item is accepted until it ends.
module xor_kbucket_routing_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rtbl_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rtbl_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [63:0]    i_cfg_data
);

    rtbl_pkg::t_cmd  cmd;
    rtbl_pkg::t_stat stat;

    // The own id register takes a beat in any cycle outside reset.
    assign o_cfg_ready = 1'b1;

    rtbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rtbl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out       (o_out)
    );

endmodule
